@@ src/jdt_pkg.sv @@
`default_nettype none
package jdt_pkg;

  // Default sizes of the stores
  localparam int unsigned CAND_SLOTS_DEF    = 16;
  localparam int unsigned ACTIVE_SLOTS_DEF  = 16;
  localparam int unsigned SESSION_SLOTS_DEF = 2;
  localparam int unsigned SESSION_BYTES_DEF = 256;

  // Register reset values
  localparam logic [31:0] WINDOW_RST  = 32'd10;
  localparam logic [7:0]  COUNT_RST   = 8'd3;
  localparam logic [31:0] TIMEOUT_RST = 32'd20;

  // Register indexes
  localparam logic [1:0] CFG_WINDOW  = 2'd0;
  localparam logic [1:0] CFG_COUNT   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  // Identifier and protocol codes
  localparam logic [15:0] PGN_DM1_PS   = 16'hFECA;
  localparam logic [23:0] PGN_DM1      = 24'h00FECA;
  localparam logic [7:0]  PF_TP_CM     = 8'hEC;
  localparam logic [7:0]  PF_TP_DT     = 8'hEB;
  localparam logic [7:0]  CTRL_BAM     = 8'h20;
  localparam logic [28:0] DT_KEEP_MASK = 29'h1F00FFFF;
  localparam logic [28:0] DT_PF_BITS   = 29'h00EB0000;

  typedef struct packed {
    logic in_ready;
    logic scan_clr;
    logic scan_inc;
    logic ann;
    logic data;
    logic pstart;
    logic rd;
    logic take;
    logic act_upd;
    logic cand_upd;
    logic cand_ins;
    logic promote;
    logic pdone;
    logic cand_rm;
    logic act_rm;
    logic chg_clr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic kind;
    logic is_dm1;
    logic is_ann;
    logic is_dat;
    logic dat_done;
    logic byte_end;
    logic grp_done;
    logic act_end;
    logic act_hit;
    logic act_exp;
    logic cand_end;
    logic cand_hit;
    logic cand_exp;
    logic prom_elig;
    logic changed;
    logic out_free;
    logic emit_last;
  } stat_t;

endpackage
`default_nettype wire

@@ src/jdt_if.sv @@
`default_nettype none
interface jdt_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [28:0] can_id;
  logic [63:0] payload;
  logic [31:0] timestamp;

  modport source (output valid, kind, can_id, payload, timestamp, input ready);
  modport sink   (input valid, kind, can_id, payload, timestamp, output ready);
endinterface

interface jdt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  source_addr;
  logic [18:0] spn;
  logic [4:0]  fmi;
  logic        conv_method;
  logic [6:0]  occ_count;
  logic [1:0]  mil_status;
  logic [1:0]  red_stop;
  logic [1:0]  amber_warn;
  logic [1:0]  protect_lamp;
  logic        last_entry;
  logic        list_empty;

  modport source (output valid, source_addr, spn, fmi, conv_method, occ_count, mil_status,
                  red_stop, amber_warn, protect_lamp, last_entry, list_empty, input ready);
  modport sink   (input valid, source_addr, spn, fmi, conv_method, occ_count, mil_status,
                  red_stop, amber_warn, protect_lamp, last_entry, list_empty, output ready);
endinterface
`default_nettype wire

@@ src/jdt_datapath.sv @@
`default_nettype none
module jdt_datapath #(
  parameter int unsigned CAND_SLOTS    = jdt_pkg::CAND_SLOTS_DEF,
  parameter int unsigned ACTIVE_SLOTS  = jdt_pkg::ACTIVE_SLOTS_DEF,
  parameter int unsigned SESSION_SLOTS = jdt_pkg::SESSION_SLOTS_DEF,
  parameter int unsigned SESSION_BYTES = jdt_pkg::SESSION_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i,
  jdt_in_if.sink         in_s,
  jdt_out_if.source      out_s,
  input  jdt_pkg::cmd_t  cmd_i,
  output jdt_pkg::stat_t stat_o
);

  localparam int unsigned CAW  = (CAND_SLOTS > 1) ? $clog2(CAND_SLOTS) : 1;
  localparam int unsigned CUW  = $clog2(CAND_SLOTS + 1);
  localparam int unsigned AAW  = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int unsigned AUW  = $clog2(ACTIVE_SLOTS + 1);
  localparam int unsigned JW   = (CUW > AUW) ? CUW : AUW;
  localparam int unsigned SW   = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
  localparam int unsigned PKTS = (SESSION_BYTES + 6) / 7;
  localparam int unsigned RW   = $clog2(PKTS);
  localparam int unsigned MAW  = SW + RW;
  localparam int unsigned DEPTH = 1 << MAW;
  localparam int unsigned LW   = $clog2(SESSION_BYTES + 1);

  // Configuration
  logic [31:0] win_q, tmo_q;
  logic [7:0]  cnt_q;

  // Accepted item
  logic        kind_q;
  logic [28:0] id_q;
  logic [63:0] pay_q;
  logic [31:0] ts_q;

  // Fault stores
  logic [31:0] cand_key_q   [CAND_SLOTS];
  logic [15:0] cand_info_q  [CAND_SLOTS];
  logic [31:0] cand_first_q [CAND_SLOTS];
  logic [7:0]  cand_occ_q   [CAND_SLOTS];
  logic [CUW-1:0] cand_used_q;
  logic [31:0] act_key_q    [ACTIVE_SLOTS];
  logic [15:0] act_info_q   [ACTIVE_SLOTS];
  logic [31:0] act_last_q   [ACTIVE_SLOTS];
  logic [AUW-1:0] act_used_q;
  logic        changed_q;
  logic [JW-1:0] j_q;

  // Transport sessions
  logic [28:0] sid_q  [SESSION_SLOTS];
  logic [15:0] stot_q [SESSION_SLOTS];
  logic [7:0]  sexp_q [SESSION_SLOTS];
  logic [7:0]  srcv_q [SESSION_SLOTS];
  logic [PKTS-1:0] rvalid_q [SESSION_SLOTS];
  logic [55:0] mem [DEPTH];
  logic [55:0] memrd_q;
  logic        rv_q;

  // Parser
  logic          pmode_q;
  logic [SW-1:0] psess_q;
  logic [LW-1:0] plen_q, bidx_q;
  logic [RW-1:0] prow_q;
  logic [2:0]    pcol_q;
  logic [7:0]    src_q, lamps_q;
  logic [31:0]   dtc_q;

  // Output register
  logic        out_valid_q;
  logic [7:0]  o_src_q;
  logic [18:0] o_spn_q;
  logic [4:0]  o_fmi_q;
  logic        o_cm_q;
  logic [6:0]  o_oc_q;
  logic [1:0]  o_mil_q, o_red_q, o_amb_q, o_prot_q;
  logic        o_last_q, o_empty_q;

  logic          accept;
  logic [CAW-1:0] jc;
  logic [AAW-1:0] ja;
  logic [31:0]   key;
  logic [15:0]   info;
  logic [7:0]    byte_v;
  logic [31:0]   cand_age, act_age;
  logic          ann_ok, own_f, free_f, pick_f;
  logic [SW-1:0] own_s, free_s, pick_s, ms;
  logic          mf, dat_ok, row_ok;
  logic [7:0]    seq, seqm1, rcv_new;
  logic [15:0]   ms_tot;
  logic [LW-1:0] ms_len;
  logic          cand_room, act_room;

  assign accept = in_s.valid && cmd_i.in_ready;
  assign in_s.ready = cmd_i.in_ready;
  assign jc = j_q[CAW-1:0];
  assign ja = j_q[AAW-1:0];

  assign key  = {src_q, dtc_q[23:21], dtc_q[15:8], dtc_q[7:0], dtc_q[20:16]};
  assign info = {dtc_q[31], dtc_q[30:24], lamps_q};
  assign byte_v = pmode_q ? (rv_q ? memrd_q[{pcol_q, 3'b000} +: 8] : 8'h00)
                          : pay_q[{bidx_q[2:0], 3'b000} +: 8];
  assign cand_age = ts_q - cand_first_q[jc];
  assign act_age  = ts_q - act_last_q[ja];
  assign cand_room = cand_used_q < CUW'(CAND_SLOTS);
  assign act_room  = act_used_q < AUW'(ACTIVE_SLOTS);

  // Announce slot choice: own session first, else the first free one
  assign ann_ok = ({pay_q[63:56], pay_q[55:48], pay_q[47:40]} == jdt_pkg::PGN_DM1) &&
                  (pay_q[7:0] == jdt_pkg::CTRL_BAM);
  always_comb begin
    own_f = 1'b0; free_f = 1'b0; own_s = '0; free_s = '0;
    mf = 1'b0; ms = '0;
    for (int s = SESSION_SLOTS - 1; s >= 0; s--) begin
      if (sid_q[s] == id_q) begin
        own_f = 1'b1; own_s = SW'(s);
      end
      if (sid_q[s] == '0) begin
        free_f = 1'b1; free_s = SW'(s);
      end
      if (sid_q[s] != '0 &&
          (((sid_q[s] & jdt_pkg::DT_KEEP_MASK) | jdt_pkg::DT_PF_BITS) == id_q)) begin
        mf = 1'b1; ms = SW'(s);
      end
    end
  end
  assign pick_f = own_f || free_f;
  assign pick_s = own_f ? own_s : free_s;

  assign seq     = pay_q[7:0];
  assign seqm1   = seq - 8'd1;
  assign dat_ok  = mf && (seq != 8'd0) && (seq <= sexp_q[ms]);
  assign row_ok  = seqm1 < 8'(PKTS);
  assign rcv_new = (srcv_q[ms] == 8'hFF) ? 8'hFF : srcv_q[ms] + 8'd1;
  assign ms_tot  = stot_q[ms];
  assign ms_len  = (ms_tot > 16'(SESSION_BYTES)) ? LW'(SESSION_BYTES) : ms_tot[LW-1:0];

  always_comb begin
    stat_o.in_valid  = in_s.valid;
    stat_o.kind      = kind_q;
    stat_o.is_dm1    = id_q[23:8] == jdt_pkg::PGN_DM1_PS;
    stat_o.is_ann    = id_q[23:16] == jdt_pkg::PF_TP_CM;
    stat_o.is_dat    = id_q[23:16] == jdt_pkg::PF_TP_DT;
    stat_o.dat_done  = dat_ok && (rcv_new == sexp_q[ms]);
    stat_o.byte_end  = bidx_q == plen_q;
    stat_o.grp_done  = (bidx_q >= LW'(5)) && (bidx_q[1:0] == 2'b01);
    stat_o.act_end   = j_q >= JW'(act_used_q);
    stat_o.act_hit   = act_key_q[ja] == key;
    stat_o.act_exp   = act_age > tmo_q;
    stat_o.cand_end  = j_q >= JW'(cand_used_q);
    stat_o.cand_hit  = cand_key_q[jc] == key;
    stat_o.cand_exp  = cand_age > win_q;
    stat_o.prom_elig = (cand_age <= win_q) && (cand_occ_q[jc] >= cnt_q);
    stat_o.changed   = changed_q;
    stat_o.out_free  = !out_valid_q || out_s.ready;
    stat_o.emit_last = (act_used_q == '0) || (j_q + JW'(1) == JW'(act_used_q));
  end

  // Latched item, parser and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_s.kind;
      id_q   <= in_s.can_id;
      pay_q  <= in_s.payload;
      ts_q   <= in_s.timestamp;
    end
    if (cmd_i.pstart || (cmd_i.data && stat_o.dat_done)) begin
      pmode_q <= cmd_i.data;
      psess_q <= ms;
      plen_q  <= cmd_i.data ? ms_len : LW'(8);
      bidx_q  <= '0;
      prow_q  <= '0;
      pcol_q  <= '0;
      src_q   <= id_q[7:0];
    end
    if (cmd_i.rd) begin
      memrd_q <= mem[{psess_q, prow_q}];
      rv_q    <= rvalid_q[psess_q][prow_q];
    end
    if (cmd_i.take) begin
      if (bidx_q == '0) lamps_q <= byte_v;
      dtc_q  <= {byte_v, dtc_q[31:8]};
      bidx_q <= bidx_q + LW'(1);
      if (pcol_q == 3'd6) begin
        pcol_q <= '0;
        prow_q <= prow_q + RW'(1);
      end else begin
        pcol_q <= pcol_q + 3'd1;
      end
    end
    if (cmd_i.data && dat_ok && row_ok) mem[{ms, seqm1[RW-1:0]}] <= pay_q[63:8];
    if (cmd_i.emit) begin
      if (act_used_q == '0) begin
        {o_src_q, o_spn_q, o_fmi_q, o_cm_q, o_oc_q} <= '0;
        {o_mil_q, o_red_q, o_amb_q, o_prot_q, o_last_q} <= '0;
        o_empty_q <= 1'b1;
      end else begin
        o_src_q   <= act_key_q[ja][31:24];
        o_spn_q   <= act_key_q[ja][23:5];
        o_fmi_q   <= act_key_q[ja][4:0];
        o_cm_q    <= act_info_q[ja][15];
        o_oc_q    <= act_info_q[ja][14:8];
        o_mil_q   <= act_info_q[ja][7:6];
        o_red_q   <= act_info_q[ja][5:4];
        o_amb_q   <= act_info_q[ja][3:2];
        o_prot_q  <= act_info_q[ja][1:0];
        o_last_q  <= stat_o.emit_last;
        o_empty_q <= 1'b0;
      end
    end
  end

  // Candidate and active entries: insert, refresh, and close the gap on removal
  always_ff @(posedge clk_i) begin
    if (cmd_i.cand_ins && cand_room) begin
      cand_key_q[cand_used_q[CAW-1:0]]   <= key;
      cand_info_q[cand_used_q[CAW-1:0]]  <= info;
      cand_first_q[cand_used_q[CAW-1:0]] <= ts_q;
      cand_occ_q[cand_used_q[CAW-1:0]]   <= 8'd1;
    end
    if (cmd_i.cand_upd) begin
      if (cand_occ_q[jc] != 8'hFF) cand_occ_q[jc] <= cand_occ_q[jc] + 8'd1;
      cand_info_q[jc] <= {cand_info_q[jc][15], info[14:0]};
    end
    if (cmd_i.cand_rm || cmd_i.promote) begin
      for (int k = 0; k + 1 < CAND_SLOTS; k++) begin
        if (JW'(k) >= j_q) begin
          cand_key_q[k]   <= cand_key_q[k+1];
          cand_info_q[k]  <= cand_info_q[k+1];
          cand_first_q[k] <= cand_first_q[k+1];
          cand_occ_q[k]   <= cand_occ_q[k+1];
        end
      end
    end
    if (cmd_i.promote && act_room) begin
      act_key_q[act_used_q[AAW-1:0]]  <= cand_key_q[jc];
      act_info_q[act_used_q[AAW-1:0]] <= cand_info_q[jc];
      act_last_q[act_used_q[AAW-1:0]] <= ts_q;
    end
    if (cmd_i.act_upd) begin
      act_info_q[ja] <= {act_info_q[ja][15], info[14:0]};
      act_last_q[ja] <= ts_q;
    end
    if (cmd_i.act_rm) begin
      for (int k = 0; k + 1 < ACTIVE_SLOTS; k++) begin
        if (JW'(k) >= j_q) begin
          act_key_q[k]  <= act_key_q[k+1];
          act_info_q[k] <= act_info_q[k+1];
          act_last_q[k] <= act_last_q[k+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= jdt_pkg::WINDOW_RST;
      cnt_q       <= jdt_pkg::COUNT_RST;
      tmo_q       <= jdt_pkg::TIMEOUT_RST;
      cand_used_q <= '0;
      act_used_q  <= '0;
      changed_q   <= 1'b0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < SESSION_SLOTS; s++) begin
        sid_q[s]    <= '0;
        stot_q[s]   <= '0;
        sexp_q[s]   <= '0;
        srcv_q[s]   <= '0;
        rvalid_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          jdt_pkg::CFG_WINDOW:  win_q <= cfg_data_i;
          jdt_pkg::CFG_COUNT:   cnt_q <= cfg_data_i[7:0];
          jdt_pkg::CFG_TIMEOUT: tmo_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.scan_clr) j_q <= '0;
      else if (cmd_i.scan_inc || cmd_i.emit) j_q <= j_q + JW'(1);

      if (cmd_i.cand_ins && cand_room) cand_used_q <= cand_used_q + CUW'(1);
      else if (cmd_i.cand_rm || cmd_i.promote) cand_used_q <= cand_used_q - CUW'(1);

      if (cmd_i.promote && act_room) act_used_q <= act_used_q + AUW'(1);
      else if (cmd_i.act_rm) act_used_q <= act_used_q - AUW'(1);

      if (cmd_i.promote || cmd_i.act_rm) changed_q <= 1'b1;
      else if (cmd_i.chg_clr) changed_q <= 1'b0;

      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_s.ready) out_valid_q <= 1'b0;

      if (cmd_i.ann && ann_ok && pick_f) begin
        sid_q[pick_s]    <= id_q;
        stot_q[pick_s]   <= {pay_q[23:16], pay_q[15:8]};
        sexp_q[pick_s]   <= pay_q[31:24];
        srcv_q[pick_s]   <= '0;
        rvalid_q[pick_s] <= '0;
      end
      if (cmd_i.data && dat_ok) begin
        srcv_q[ms] <= rcv_new;
        if (row_ok) rvalid_q[ms][seqm1[RW-1:0]] <= 1'b1;
      end
      // Release the session once its message has been parsed
      if (cmd_i.pdone && pmode_q) begin
        sid_q[psess_q]    <= '0;
        stot_q[psess_q]   <= '0;
        sexp_q[psess_q]   <= '0;
        srcv_q[psess_q]   <= '0;
        rvalid_q[psess_q] <= '0;
      end
    end
  end

  assign out_s.valid        = out_valid_q;
  assign out_s.source_addr  = o_src_q;
  assign out_s.spn          = o_spn_q;
  assign out_s.fmi          = o_fmi_q;
  assign out_s.conv_method  = o_cm_q;
  assign out_s.occ_count    = o_oc_q;
  assign out_s.mil_status   = o_mil_q;
  assign out_s.red_stop     = o_red_q;
  assign out_s.amber_warn   = o_amb_q;
  assign out_s.protect_lamp = o_prot_q;
  assign out_s.last_entry   = o_last_q;
  assign out_s.list_empty   = o_empty_q;

endmodule
`default_nettype wire

@@ src/jdt_ctrl.sv @@
`default_nettype none
module jdt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jdt_pkg::stat_t stat_i,
  output jdt_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_DATA  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_BYTE  = 4'd4;
  localparam logic [3:0] S_SACT  = 4'd5;
  localparam logic [3:0] S_SCAND = 4'd6;
  localparam logic [3:0] S_PROM  = 4'd7;
  localparam logic [3:0] S_CEXP  = 4'd8;
  localparam logic [3:0] S_AEXP  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) state_d = S_DISP;
      end
      S_DISP: begin
        if (stat_i.kind) begin
          cmd_o.scan_clr = 1'b1;
          state_d = S_CEXP;
        end else if (stat_i.is_dm1) begin
          cmd_o.pstart = 1'b1;
          state_d = S_RD;
        end else if (stat_i.is_ann) begin
          cmd_o.ann = 1'b1;
          state_d = S_IDLE;
        end else if (stat_i.is_dat) begin
          state_d = S_DATA;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DATA: begin
        cmd_o.data = 1'b1;
        state_d = stat_i.dat_done ? S_RD : S_IDLE;
      end
      S_RD: begin
        if (stat_i.byte_end) begin
          cmd_o.scan_clr = 1'b1;
          state_d = S_PROM;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = S_BYTE;
        end
      end
      S_BYTE: begin
        cmd_o.take = 1'b1;
        if (stat_i.grp_done) begin
          cmd_o.scan_clr = 1'b1;
          state_d = S_SACT;
        end else begin
          state_d = S_RD;
        end
      end
      S_SACT: begin
        if (stat_i.act_end) begin
          cmd_o.scan_clr = 1'b1;
          state_d = S_SCAND;
        end else if (stat_i.act_hit) begin
          cmd_o.act_upd = 1'b1;
          state_d = S_RD;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_SCAND: begin
        if (stat_i.cand_end) begin
          cmd_o.cand_ins = 1'b1;
          state_d = S_RD;
        end else if (stat_i.cand_hit) begin
          cmd_o.cand_upd = 1'b1;
          state_d = S_RD;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_PROM: begin
        if (stat_i.cand_end) begin
          cmd_o.pdone = 1'b1;
          state_d = S_IDLE;
        end else if (stat_i.prom_elig) begin
          cmd_o.promote = 1'b1;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_CEXP: begin
        if (stat_i.cand_end) begin
          cmd_o.scan_clr = 1'b1;
          state_d = S_AEXP;
        end else if (stat_i.cand_exp) begin
          cmd_o.cand_rm = 1'b1;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_AEXP: begin
        if (stat_i.act_end) begin
          if (stat_i.changed) begin
            cmd_o.chg_clr  = 1'b1;
            cmd_o.scan_clr = 1'b1;
            state_d = S_EMIT;
          end else begin
            state_d = S_IDLE;
          end
        end else if (stat_i.act_exp) begin
          cmd_o.act_rm = 1'b1;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.emit_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ src/j1939_dtc_debounce_tracker.sv @@
`default_nettype none
// Channel   Dir  Role       Payload
// frame_i   in   sink       kind, can_id, payload, timestamp
// dtc_o     out  source     source_addr .. protect_lamp, last_entry, list_empty
// cfg_*     in   write      cfg_idx_i selects window, count or timeout
//
// One request at a time: it is taken in idle, then dispatched by kind; a data packet
// also updates its session. A DM1 message then reads its bytes one by one; per DTC, it scans
// the active and then the candidate entries; then it scans the candidates to promote.
// A check scans the candidates, then the active entries, then reports each active fault.
// Reset clears tables, sessions and the report flag at once; no sweep is needed.
// A stalled sink holds the report, and no request is taken until its last entry is registered.
module j1939_dtc_debounce_tracker #(
  parameter int unsigned CAND_SLOTS    = jdt_pkg::CAND_SLOTS_DEF,
  parameter int unsigned ACTIVE_SLOTS  = jdt_pkg::ACTIVE_SLOTS_DEF,
  parameter int unsigned SESSION_SLOTS = jdt_pkg::SESSION_SLOTS_DEF,
  parameter int unsigned SESSION_BYTES = jdt_pkg::SESSION_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  jdt_in_if.sink      frame_i,
  jdt_out_if.source   dtc_o
);

  jdt_pkg::cmd_t  cmd;
  jdt_pkg::stat_t stat;

  // Sequence each request
  jdt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Hold tables, sessions and the result register
  jdt_datapath #(
    .CAND_SLOTS    (CAND_SLOTS),
    .ACTIVE_SLOTS  (ACTIVE_SLOTS),
    .SESSION_SLOTS (SESSION_SLOTS),
    .SESSION_BYTES (SESSION_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (frame_i),
    .out_s      (dtc_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule
`default_nettype wire

@@ bench/dtc_list_checker.sv @@
`timescale 1ns / 1ps
module dtc_list_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  jdt_in_if           frame_i,
  jdt_out_if          dtc_o,
  output int unsigned err_count_o,
  output int unsigned pending_o
);

  localparam int NC = jdt_pkg::CAND_SLOTS_DEF;
  localparam int NA = jdt_pkg::ACTIVE_SLOTS_DEF;
  localparam int NS = jdt_pkg::SESSION_SLOTS_DEF;
  localparam int NB = jdt_pkg::SESSION_BYTES_DEF;

  typedef struct packed {
    logic [7:0]  sa;
    logic [18:0] spn;
    logic [4:0]  fmi;
    logic        cm;
    logic [6:0]  oc;
    logic [1:0]  mil;
    logic [1:0]  red;
    logic [1:0]  amber;
    logic [1:0]  prot;
    logic        last;
    logic        empty;
  } fault_t;

  fault_t expected_faults[$];

  logic [31:0] win, tmo;
  logic [7:0]  cnt;

  logic [31:0] c_key[NC];
  logic [15:0] c_info[NC];
  logic [31:0] c_first[NC];
  logic [7:0]  c_occ[NC];
  int          c_n;
  logic [31:0] a_key[NA];
  logic [15:0] a_info[NA];
  logic [31:0] a_last[NA];
  int          a_n;
  logic        changed;

  logic [28:0] s_id[NS];
  logic [15:0] s_total[NS];
  logic [7:0]  s_exp[NS];
  logic [7:0]  s_rcv[NS];
  logic [7:0]  s_buf[NS][NB];
  logic [7:0]  msg[NB];

  int unsigned errs;

  task automatic sess_clear(int s);
    s_id[s] = '0;
    s_total[s] = '0;
    s_exp[s] = '0;
    s_rcv[s] = '0;
    for (int k = 0; k < NB; k++) s_buf[s][k] = '0;
  endtask

  task automatic tracker_reset();
    win = jdt_pkg::WINDOW_RST;
    cnt = jdt_pkg::COUNT_RST;
    tmo = jdt_pkg::TIMEOUT_RST;
    c_n = 0;
    a_n = 0;
    changed = 1'b0;
    for (int s = 0; s < NS; s++) sess_clear(s);
    expected_faults.delete();
  endtask

  task automatic cand_drop(int i);
    for (int j = i; j + 1 < c_n; j++) begin
      c_key[j] = c_key[j+1];
      c_info[j] = c_info[j+1];
      c_first[j] = c_first[j+1];
      c_occ[j] = c_occ[j+1];
    end
    c_n--;
  endtask

  task automatic act_drop(int i);
    for (int j = i; j + 1 < a_n; j++) begin
      a_key[j] = a_key[j+1];
      a_info[j] = a_info[j+1];
      a_last[j] = a_last[j+1];
    end
    a_n--;
  endtask

  task automatic promote_ready(logic [31:0] ts);
    int i;
    logic [31:0] age;
    i = 0;
    while (i < c_n) begin
      age = ts - c_first[i];
      if (age <= win && c_occ[i] >= cnt) begin
        if (a_n < NA) begin
          a_key[a_n] = c_key[i];
          a_info[a_n] = c_info[i];
          a_last[a_n] = ts;
          a_n++;
        end
        cand_drop(i);
        changed = 1'b1;
      end else begin
        i++;
      end
    end
  endtask

  task automatic note_dtc(logic [31:0] key, logic cm, logic [6:0] oc, logic [7:0] lamps,
                          logic [31:0] ts);
    for (int i = 0; i < a_n; i++) begin
      if (a_key[i] == key) begin
        a_info[i] = {a_info[i][15], oc, lamps};
        a_last[i] = ts;
        return;
      end
    end
    for (int i = 0; i < c_n; i++) begin
      if (c_key[i] == key) begin
        if (c_occ[i] != 8'hFF) c_occ[i]++;
        c_info[i] = {c_info[i][15], oc, lamps};
        return;
      end
    end
    if (c_n < NC) begin
      c_key[c_n] = key;
      c_info[c_n] = {cm, oc, lamps};
      c_first[c_n] = ts;
      c_occ[c_n] = 8'd1;
      c_n++;
    end
  endtask

  // msg holds the message bytes
  task automatic parse_dm1(logic [7:0] src, int len, logic [31:0] ts);
    logic [18:0] spn;
    for (int i = 2; i + 4 <= len; i += 4) begin
      spn = {msg[i+2][7:5], msg[i+1], msg[i]};
      note_dtc({src, spn, msg[i+2][4:0]}, msg[i+3][7], msg[i+3][6:0], msg[0], ts);
    end
    promote_ready(ts);
  endtask

  task automatic on_announce(logic [28:0] id, logic [63:0] pl);
    int pick;
    pick = NS;
    if (pl[63:40] != jdt_pkg::PGN_DM1 || pl[7:0] != jdt_pkg::CTRL_BAM) return;
    for (int s = NS - 1; s >= 0; s--) if (s_id[s] == id) pick = s;
    if (pick == NS)
      for (int s = NS - 1; s >= 0; s--) if (s_id[s] == '0) pick = s;
    if (pick == NS) return;
    sess_clear(pick);
    s_id[pick] = id;
    s_total[pick] = pl[23:8];
    s_exp[pick] = pl[31:24];
  endtask

  task automatic on_data(logic [28:0] id, logic [63:0] pl, logic [31:0] ts);
    int s, off, len;
    s = NS;
    for (int k = NS - 1; k >= 0; k--)
      if (s_id[k] != '0 &&
          ((s_id[k] & jdt_pkg::DT_KEEP_MASK) | jdt_pkg::DT_PF_BITS) == id) s = k;
    if (s == NS) return;
    if (pl[7:0] == 8'd0 || pl[7:0] > s_exp[s]) return;
    off = (int'(pl[7:0]) - 1) * 7;
    for (int k = 0; k < 7; k++)
      if (off + k < NB) s_buf[s][off+k] = pl[8*(k+1) +: 8];
    if (s_rcv[s] != 8'hFF) s_rcv[s]++;
    if (s_rcv[s] == s_exp[s]) begin
      len = (s_total[s] > NB) ? NB : int'(s_total[s]);
      for (int k = 0; k < NB; k++) msg[k] = s_buf[s][k];
      parse_dm1(id[7:0], len, ts);
      sess_clear(s);
    end
  endtask

  task automatic on_check(logic [31:0] ts);
    int i;
    fault_t f;
    i = 0;
    while (i < c_n) begin
      if (32'(ts - c_first[i]) > win) cand_drop(i);
      else i++;
    end
    i = 0;
    while (i < a_n) begin
      if (32'(ts - a_last[i]) > tmo) begin
        act_drop(i);
        changed = 1'b1;
      end else begin
        i++;
      end
    end
    if (!changed) return;
    changed = 1'b0;
    if (a_n == 0) begin
      f = '0;
      f.empty = 1'b1;
      expected_faults.push_back(f);
      return;
    end
    for (int k = 0; k < a_n; k++) begin
      f.sa = a_key[k][31:24];
      f.spn = a_key[k][23:5];
      f.fmi = a_key[k][4:0];
      f.cm = a_info[k][15];
      f.oc = a_info[k][14:8];
      f.mil = a_info[k][7:6];
      f.red = a_info[k][5:4];
      f.amber = a_info[k][3:2];
      f.prot = a_info[k][1:0];
      f.last = (k == a_n - 1);
      f.empty = 1'b0;
      expected_faults.push_back(f);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
    errs++;
  endtask

  task automatic cmp(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fault_t e;
    if (!rst_ni) begin
      tracker_reset();
      errs = 0;
    end else begin
      // compare the result first, then take the new request
      if (dtc_o.valid && dtc_o.ready) begin
        if (expected_faults.size() == 0) begin
          report("result with nothing expected", 32'(dtc_o.spn), 32'd0);
        end else begin
          e = expected_faults.pop_front();
          cmp("source_addr", 32'(dtc_o.source_addr), 32'(e.sa));
          cmp("spn", 32'(dtc_o.spn), 32'(e.spn));
          cmp("fmi", 32'(dtc_o.fmi), 32'(e.fmi));
          cmp("conv_method", 32'(dtc_o.conv_method), 32'(e.cm));
          cmp("occ_count", 32'(dtc_o.occ_count), 32'(e.oc));
          cmp("mil_status", 32'(dtc_o.mil_status), 32'(e.mil));
          cmp("red_stop", 32'(dtc_o.red_stop), 32'(e.red));
          cmp("amber_warn", 32'(dtc_o.amber_warn), 32'(e.amber));
          cmp("protect_lamp", 32'(dtc_o.protect_lamp), 32'(e.prot));
          cmp("last_entry", 32'(dtc_o.last_entry), 32'(e.last));
          cmp("list_empty", 32'(dtc_o.list_empty), 32'(e.empty));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          jdt_pkg::CFG_WINDOW:  win = cfg_data_i;
          jdt_pkg::CFG_COUNT:   cnt = cfg_data_i[7:0];
          jdt_pkg::CFG_TIMEOUT: tmo = cfg_data_i;
          default: ;
        endcase
      end
      if (frame_i.valid && frame_i.ready) begin
        if (frame_i.kind) begin
          on_check(frame_i.timestamp);
        end else if (frame_i.can_id[23:8] == jdt_pkg::PGN_DM1_PS) begin
          for (int k = 0; k < 8; k++) msg[k] = frame_i.payload[8*k +: 8];
          parse_dm1(frame_i.can_id[7:0], 8, frame_i.timestamp);
        end else if (frame_i.can_id[23:16] == jdt_pkg::PF_TP_CM) begin
          on_announce(frame_i.can_id, frame_i.payload);
        end else if (frame_i.can_id[23:16] == jdt_pkg::PF_TP_DT) begin
          on_data(frame_i.can_id, frame_i.payload, frame_i.timestamp);
        end
      end
    end
    err_count_o <= errs;
    pending_o <= $unsigned(expected_faults.size());
  end

endmodule

@@ bench/tb_j1939_dtc_debounce_tracker.sv @@
`timescale 1ns / 1ps
module tb_j1939_dtc_debounce_tracker;

  // cycles with no request or result moving before the run is called hung
  localparam int IDLE_LIMIT = 20000;
  // settle time after the last result: a long BAM parse has no result to wait on
  localparam int SETTLE = 2000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  jdt_in_if  fr ();
  jdt_out_if dq ();

  int unsigned chk_errors, chk_pending;

  j1939_dtc_debounce_tracker dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .frame_i    (fr),
    .dtc_o      (dq)
  );

  dtc_list_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .frame_i     (fr),
    .dtc_o       (dq),
    .err_count_o (chk_errors),
    .pending_o   (chk_pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // no idling on either side once set
  bit quiet;

  // Sink: ready in random bursts of stalls and runs
  int stall_left, run_left;
  always @(posedge clk) begin
    if (quiet) begin
      dq.ready <= 1'b1;
    end else if (stall_left > 0) begin
      dq.ready <= 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      dq.ready <= 1'b1;
      run_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 10);
      dq.ready <= 1'b0;
      stall_left--;
    end else begin
      run_left = $urandom_range(1, 20);
      dq.ready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which nothing moves
  int idle_cycles;
  always @(posedge clk) begin
    if ((fr.valid && fr.ready) || (dq.valid && dq.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  logic [31:0] now_ts;
  int          sent;
  bit          distinct;

  // pools keep sightings repeating so candidates get promoted
  logic [18:0] pool_spn[8];
  logic [4:0]  pool_fmi[8];
  logic [7:0]  sa_pool[4];
  logic [4:0]  top_pool[4];
  logic [7:0]  da_pool[4];
  logic [7:0]  msg[300];

  // Hold a request until taken; then maybe drop valid for a burst
  task automatic send_item(logic kind, logic [28:0] id, logic [63:0] pl);
    fr.valid <= 1'b1;
    fr.kind <= kind;
    fr.can_id <= id;
    fr.payload <= pl;
    fr.timestamp <= now_ts;
    @(posedge clk);
    while (!fr.ready) @(posedge clk);
    sent++;
    now_ts = now_ts + $urandom_range(0, 3);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      fr.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_check();
    send_item(1'b1, 29'($urandom), {$urandom, $urandom});
  endtask

  function automatic logic [31:0] dtc_word(logic [18:0] spn, logic [4:0] fmi, logic cm,
                                           logic [6:0] oc);
    return {cm, oc, spn[18:16], fmi, spn[15:8], spn[7:0]};
  endfunction

  function automatic logic [31:0] pick_dtc();
    int p;
    p = $urandom_range(0, 7);
    if (distinct) return dtc_word(19'($urandom), 5'($urandom), 1'($urandom), 7'($urandom));
    return dtc_word(pool_spn[p], pool_fmi[p], 1'($urandom), 7'($urandom));
  endfunction

  // One-frame DM1: lamps, reserved byte, one DTC, two trailing bytes of a partial DTC
  task automatic send_dm1(logic [7:0] sa, logic [31:0] w, logic [7:0] lamps);
    send_item(1'b0, {5'($urandom), jdt_pkg::PGN_DM1_PS, sa},
              {16'($urandom), w, 8'($urandom), lamps});
  endtask

  task automatic send_pool_dm1();
    logic [7:0] sa;
    sa = distinct ? 8'($urandom) : sa_pool[$urandom_range(0, 3)];
    send_dm1(sa, pick_dtc(), 8'($urandom));
  endtask

  typedef enum int {BAM_CLEAN, BAM_DUP, BAM_BADSEQ, BAM_ABORT, BAM_BADANN, BAM_ZERO} bam_mode_e;

  // BAM session on slot s of the pools
  task automatic send_bam(int s, int ndtc, int extra, bam_mode_e mode);
    int len, pkts, stop;
    logic [28:0] ann_id, dt_id;
    logic [63:0] pl;
    logic [7:0]  ctrl;
    logic [23:0] pgn;
    len = 2 + 4 * ndtc + extra;
    pkts = (len + 6) / 7;
    for (int k = 0; k < 300; k++) msg[k] = 8'($urandom);
    for (int k = 0; k < ndtc && 2 + 4 * k + 3 < 300; k++)
      {msg[2+4*k+3], msg[2+4*k+2], msg[2+4*k+1], msg[2+4*k]} = pick_dtc();
    ann_id = {top_pool[s], jdt_pkg::PF_TP_CM, da_pool[s], sa_pool[s]};
    dt_id = {top_pool[s], jdt_pkg::PF_TP_DT, da_pool[s], sa_pool[s]};
    ctrl = jdt_pkg::CTRL_BAM;
    pgn = jdt_pkg::PGN_DM1;
    if (mode == BAM_BADANN) begin
      if ($urandom_range(0, 1) == 0) ctrl = 8'h10;
      else pgn = jdt_pkg::PGN_DM1 ^ 24'(1 << $urandom_range(0, 23));
    end
    send_item(1'b0, ann_id, {pgn, 8'($urandom),
                             (mode == BAM_ZERO) ? 8'd0 : 8'(pkts), 16'(len), ctrl});
    if (mode == BAM_ZERO || mode == BAM_BADANN) begin
      // data to a session that will not complete
      send_item(1'b0, dt_id, {$urandom, 24'($urandom), 8'd1});
      return;
    end
    if (mode == BAM_BADSEQ) begin
      send_item(1'b0, dt_id, {{$urandom, 24'($urandom)}, 8'd0});
      send_item(1'b0, dt_id, {{$urandom, 24'($urandom)}, 8'(pkts + $urandom_range(1, 3))});
    end
    stop = (mode == BAM_ABORT) ? pkts / 2 : pkts;
    for (int k = 1; k <= stop; k++) begin
      for (int b = 0; b < 7; b++) pl[8*(b+1) +: 8] = ((k-1)*7 + b < 300) ? msg[(k-1)*7+b] : 8'h00;
      pl[7:0] = 8'(k);
      send_item(1'b0, dt_id, pl);
      if (mode == BAM_DUP && k == 1) send_item(1'b0, dt_id, pl);
      // an unrelated frame in the middle of the session now and then
      if ($urandom_range(0, 9) == 0) send_pool_dm1();
    end
  endtask

  task automatic send_noise();
    send_item(1'b0, 29'($urandom), {$urandom, $urandom});
  endtask

  // Hold the sender until every expected result is back and the block has settled
  task automatic drain();
    fr.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] w, logic [7:0] c, logic [31:0] t);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= jdt_pkg::CFG_WINDOW;
    cfg_data <= w;
    @(posedge clk);
    cfg_idx <= jdt_pkg::CFG_COUNT;
    cfg_data <= {24'($urandom), c};
    @(posedge clk);
    cfg_idx <= jdt_pkg::CFG_TIMEOUT;
    cfg_data <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed DM1 traffic and sessions, some checks, some noise
  task automatic run_phase(int goal);
    int r;
    goal = sent + goal;
    while (sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 35) send_pool_dm1();
      else if (r < 55) send_bam($urandom_range(0, 3), $urandom_range(1, 3),
                                $urandom_range(0, 3), BAM_CLEAN);
      else if (r < 75) send_check();
      else if (r < 85) send_noise();
      else send_bam($urandom_range(0, 3), $urandom_range(1, 3), $urandom_range(0, 2),
                    bam_mode_e'($urandom_range(BAM_DUP, BAM_ZERO)));
    end
  endtask

  initial begin
    logic [31:0] w;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = jdt_pkg::CFG_WINDOW;
    cfg_data = '0;
    fr.valid = 1'b0;
    fr.kind = 1'b0;
    fr.can_id = '0;
    fr.payload = '0;
    fr.timestamp = '0;
    quiet = 1'b0;
    distinct = 1'b0;
    now_ts = '0;
    sent = 0;
    for (int k = 0; k < 8; k++) begin
      pool_spn[k] = 19'($urandom);
      pool_fmi[k] = 5'($urandom);
    end
    for (int k = 0; k < 4; k++) begin
      sa_pool[k] = 8'($urandom);
      top_pool[k] = 5'($urandom);
      da_pool[k] = 8'($urandom);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: nothing changed yet, so the check is silent
    send_check();
    // three sightings within the window promote, a fourth refreshes the active entry
    w = dtc_word(pool_spn[0], pool_fmi[0], 1'b1, 7'd5);
    repeat (3) send_dm1(sa_pool[0], w, 8'h5A);
    send_dm1(sa_pool[0], dtc_word(pool_spn[0], pool_fmi[0], 1'b0, 7'd9), 8'hA5);
    send_check();
    send_check();
    // let the active fault age out: report of an empty list
    now_ts = now_ts + 30;
    send_check();
    // extremes of every DTC field, promoted in one go
    w = dtc_word('1, '1, 1'b1, '1);
    repeat (3) send_dm1(8'hFF, w, 8'hFF);
    send_dm1(8'h00, dtc_word('0, '0, 1'b0, '0), 8'h00);
    send_check();
    // clean two-DTC session, bad announce, stray sequence, zero-packet announce
    send_bam(1, 2, 0, BAM_CLEAN);
    send_bam(2, 1, 0, BAM_BADANN);
    send_bam(3, 1, 0, BAM_BADSEQ);
    send_bam(3, 1, 0, BAM_ZERO);
    send_bam(3, 2, 1, BAM_CLEAN);
    send_check();

    run_phase(20);

    // everything promotes at once and stays: fill the active table
    set_regs('1, 8'd1, '1);
    now_ts = $urandom;
    distinct = 1'b1;
    repeat (20) send_pool_dm1();
    send_check();
    run_phase(15);
    distinct = 1'b0;

    // zero window, zero count, zero timeout
    set_regs('0, 8'd0, '0);
    run_phase(20);

    // time wraps through zero; one session longer than the reassembly store
    set_regs(32'd40, 8'd2, 32'd60);
    now_ts = 32'hFFFF_FFF0;
    run_phase(10);
    send_bam(0, 70, 0, BAM_CLEAN);
    send_check();
    run_phase(10);

    // count at its top: nothing promotes, short timeout empties the list
    set_regs(32'd1000, 8'd255, 32'd5);
    run_phase(15);
    now_ts = now_ts + 100;
    send_check();

    // last part with no idling on either side
    set_regs(jdt_pkg::WINDOW_RST, jdt_pkg::COUNT_RST, jdt_pkg::TIMEOUT_RST);
    quiet = 1'b1;
    run_phase(20);
    send_check();

    drain();
    if (chk_pending != 0) $display("%0d expected results never arrived", chk_pending);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/jdt_pkg.sv
src/jdt_if.sv
src/jdt_datapath.sv
src/jdt_ctrl.sv
src/j1939_dtc_debounce_tracker.sv
bench/dtc_list_checker.sv
bench/tb_j1939_dtc_debounce_tracker.sv
